@@ rtl/core/case_insensitive_unique_word_counter_defines.svh @@
// Assertion macros shared by the word counter modules.
`ifndef CASE_INSENSITIVE_UNIQUE_WORD_COUNTER_DEFINES_SVH
`define CASE_INSENSITIVE_UNIQUE_WORD_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define CUWC_ASSERT(name_, clk_, rstn_, prop_, msg_) \
  name_: assert property (@(posedge clk_) disable iff (!rstn_) prop_) else $error(msg_);

// Check a property on every clock edge, reset included.
`define CUWC_ASSERT_ALWAYS(name_, clk_, prop_, msg_) \
  name_: assert property (@(posedge clk_) prop_) else $error(msg_);

`else

`define CUWC_ASSERT(name_, clk_, rstn_, prop_, msg_)
`define CUWC_ASSERT_ALWAYS(name_, clk_, prop_, msg_)

`endif

`endif

@@ rtl/core/cuwc_pkg.sv @@
`default_nettype none

package cuwc_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned WordChars    = 8;
  localparam int unsigned WordBytes    = 8;
  localparam int unsigned WordW        = 8 * WordBytes;
  localparam int unsigned LenW         = 4;
  localparam int unsigned CountW       = 5;

  localparam logic [CountW-1:0] CountMax    = 5'd31;
  localparam logic [7:0]        CaseOffset  = 8'd32;
  localparam logic [7:0]        CharUpperA  = 8'h41;
  localparam logic [7:0]        CharUpperZ  = 8'h5A;

  typedef struct packed {
    logic [WordW-1:0] word_chars;
    logic [LenW-1:0]  word_len;
    logic             last_word;
  } req_t;

  typedef struct packed {
    logic              is_new;
    logic [CountW-1:0] distinct_count;
    logic              table_full;
    logic              list_done;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic read;
    logic hit;
    logic step;
    logic resolve;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic scan_end;
    logic match;
  } sts_t;

  typedef enum logic [1:0] {
    StIdle,
    StLookup,
    StCompare,
    StResolve
  } state_e;

endpackage

`default_nettype wire

@@ rtl/core/case_insensitive_unique_word_counter.sv @@
`default_nettype none

// Case-insensitive distinct word counter.
// Request: raise start_i with req_i (word_chars, word_len, last_word); the
// request is taken at a clock edge where start_i is high and busy_o is low.
// The word is masked to its length, folded to lower case and looked up in a
// table of up to TABLE_ENTRIES words held in a single-port memory that is
// scanned one entry at a time (read, then compare).
// Result: done_o strobes for exactly one cycle with rsp_o (is_new,
// distinct_count, table_full, list_done). The receiver cannot stall it.
// The scan stops at the entry that matches, ends after the entries filled so
// far when the word is absent, and is skipped when the word is overlong.
// busy_o stays high until the strobe cycle, so a new request can be taken
// in the cycle the strobe shows.
// A request with last_word set reports the final count and empties the table.
// Reset: the table is empty and the count is zero right after reset; no
// clearing pass is needed, a fill count marks the live entries.

module case_insensitive_unique_word_counter
  import cuwc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntries,
  parameter int unsigned WORD_CHARS    = WordChars
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic      busy_o,
  input  wire req_t req_i,
  output logic      done_o,
  output rsp_t      rsp_o
);

  cmd_t cmd;
  sts_t sts;

  cuwc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  cuwc_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .WORD_CHARS    (WORD_CHARS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o),
    .done_o (done_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/cuwc_ctrl.sv @@
`default_nettype none

`include "case_insensitive_unique_word_counter_defines.svh"

module cuwc_ctrl
  import cuwc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic      busy_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StLookup;
        end
      end
      StLookup: begin
        if (sts_i.skip || sts_i.scan_end) begin
          state_d = StResolve;
        end else begin
          state_d = StCompare;
        end
      end
      StCompare: begin
        if (sts_i.match) begin
          state_d = StResolve;
        end else begin
          state_d = StLookup;
        end
      end
      StResolve: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      StIdle: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      StLookup: begin
        cmd_o.read = !(sts_i.skip || sts_i.scan_end);
      end
      StCompare: begin
        cmd_o.hit  = sts_i.match;
        cmd_o.step = !sts_i.match;
      end
      StResolve: begin
        cmd_o.resolve = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `CUWC_ASSERT(a_load_to_lookup, clk_i, rst_ni, cmd_o.load |=> state_q == StLookup, "load not followed by lookup")
  `CUWC_ASSERT(a_read_to_compare, clk_i, rst_ni, cmd_o.read |=> state_q == StCompare, "read not followed by compare")
  `CUWC_ASSERT(a_resolve_single, clk_i, rst_ni, cmd_o.resolve |=> !cmd_o.resolve && !busy_o, "resolve not single cycle")

endmodule

`default_nettype wire

@@ rtl/core/cuwc_datapath.sv @@
`default_nettype none

`include "case_insensitive_unique_word_counter_defines.svh"

module cuwc_datapath
  import cuwc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntries,
  parameter int unsigned WORD_CHARS    = WordChars
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire req_t req_i,
  input  wire cmd_t cmd_i,
  output sts_t      sts_o,
  output rsp_t      rsp_o,
  output logic      done_o
);

  localparam int unsigned IdxW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned FillW = $clog2(TABLE_ENTRIES + 1);

  function automatic logic [WordW-1:0] fold_word(logic [WordW-1:0] chars,
                                                 logic [LenW-1:0] len);
    logic [WordW-1:0] res;
    logic [7:0]       b;
    res = '0;
    for (int i = 0; i < WordBytes; i++) begin
      b = chars[8*i +: 8];
      if (LenW'(i) < len) begin
        if (b inside {[CharUpperA:CharUpperZ]}) begin
          b = b + CaseOffset;
        end
        res[8*i +: 8] = b;
      end
    end
    return res;
  endfunction

  logic [WordW-1:0]  mem_q [TABLE_ENTRIES];
  logic [WordW-1:0]  rdata_q;
  logic [WordW-1:0]  word_q;
  logic              skip_q;
  logic              last_q;
  logic              found_q;
  logic [FillW-1:0]  idx_q, idx_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [CountW-1:0] count_q, count_d;
  rsp_t              rsp_q, rsp_d;
  logic              done_q;

  logic              is_new;
  logic              full;
  logic              ins;
  logic [FillW-1:0]  fill_upd;
  logic [CountW-1:0] count_upd;

  assign sts_o.skip     = skip_q;
  assign sts_o.scan_end = (idx_q == fill_q);
  assign sts_o.match    = (rdata_q == word_q);

  always_comb begin
    is_new    = !skip_q && !found_q;
    full      = is_new && (fill_q == FillW'(TABLE_ENTRIES));
    ins       = is_new && !full;
    fill_upd  = ins ? fill_q + FillW'(1) : fill_q;
    count_upd = (ins && (count_q != CountMax)) ? count_q + CountW'(1) : count_q;

    rsp_d.is_new         = is_new;
    rsp_d.distinct_count = count_upd;
    rsp_d.table_full     = full;
    rsp_d.list_done      = last_q;

    idx_d   = idx_q;
    fill_d  = fill_q;
    count_d = count_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.step) begin
      idx_d = idx_q + FillW'(1);
    end
    if (cmd_i.resolve) begin
      fill_d  = last_q ? '0 : fill_upd;
      count_d = last_q ? '0 : count_upd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve && ins) begin
      mem_q[fill_q[IdxW-1:0]] <= word_q;
    end
    if (cmd_i.read) begin
      rdata_q <= mem_q[idx_q[IdxW-1:0]];
    end
    if (cmd_i.load) begin
      word_q <= fold_word(req_i.word_chars, req_i.word_len);
      skip_q <= (req_i.word_len > LenW'(WORD_CHARS));
      last_q <= req_i.last_word;
    end
    if (cmd_i.resolve) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      fill_q  <= '0;
      count_q <= '0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      fill_q  <= fill_d;
      count_q <= count_d;
      done_q  <= cmd_i.resolve;
      if (cmd_i.load) begin
        found_q <= 1'b0;
      end else if (cmd_i.hit) begin
        found_q <= 1'b1;
      end
    end
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

  `CUWC_ASSERT_ALWAYS(a_fill_bound, clk_i, fill_q <= FillW'(TABLE_ENTRIES), "fill count past table size")
  `CUWC_ASSERT(a_count_tracks_fill, clk_i, rst_ni, (32'(fill_q) < 32'(CountMax)) ? (32'(count_q) == 32'(fill_q)) : (count_q == CountMax), "count out of step with fill")
  `CUWC_ASSERT(a_full_implies_new, clk_i, rst_ni, done_q |-> (rsp_q.is_new || !rsp_q.table_full), "table_full without new word")
  `CUWC_ASSERT(a_done_after_resolve, clk_i, rst_ni, cmd_i.resolve |=> done_q, "missing strobe after resolve")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none

module tb_top;
  import cuwc_pkg::*;

  localparam int RandomItems  = 725;
  localparam int CalmTail     = 100;
  localparam int PoolSize     = 24;
  localparam int SettleCycles = 2 * TableEntries + 8;

  typedef struct {
    req_t req;
    logic pinned;
    rsp_t rsp;
  } word_row_t;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic done_o;
  req_t req_i;
  rsp_t rsp_o;

  logic row_pinned;
  rsp_t row_rsp;

  logic [WordW-1:0]        known_word [TableEntries];
  logic [TableEntries-1:0] known_valid;
  logic [CountW-1:0]       known_count;
  rsp_t                    awaited_tallies [$];
  int                      mismatches;
  word_row_t               word_rows [$];
  logic [WordW-1:0]        pool_chars [PoolSize];
  logic [LenW-1:0]         pool_len [PoolSize];

  case_insensitive_unique_word_counter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic logic is_letter(logic [7:0] ch);
    return (ch >= CharUpperA && ch <= CharUpperZ) ||
           (ch >= CharUpperA + CaseOffset && ch <= CharUpperZ + CaseOffset);
  endfunction

  function automatic logic [WordW-1:0] fold_case(logic [WordW-1:0] chars,
                                                 logic [LenW-1:0] len);
    logic [WordW-1:0] folded;
    logic [7:0]       ch;
    folded = '0;
    for (int i = 0; i < WordChars; i++) begin
      if (i < len) begin
        ch = chars[8*i +: 8];
        if (ch >= CharUpperA && ch <= CharUpperZ) ch = ch + CaseOffset;
        folded[8*i +: 8] = ch;
      end
    end
    return folded;
  endfunction

  function automatic rsp_t tally_word(req_t r);
    rsp_t             res;
    logic [WordW-1:0] w;
    logic             found;
    int               slot;
    res = '0;
    res.list_done = r.last_word;
    if (r.word_len <= WordChars) begin
      w = fold_case(r.word_chars, r.word_len);
      found = 1'b0;
      slot = -1;
      for (int i = 0; i < TableEntries; i++) begin
        if (known_valid[i]) begin
          if (known_word[i] == w) found = 1'b1;
        end else if (slot < 0) begin
          slot = i;
        end
      end
      if (!found) begin
        res.is_new = 1'b1;
        if (slot < 0) begin
          res.table_full = 1'b1;
        end else begin
          known_word[slot] = w;
          known_valid[slot] = 1'b1;
          if (known_count < CountMax) known_count = known_count + 1'b1;
        end
      end
    end
    res.distinct_count = known_count;
    if (r.last_word) begin
      known_valid = '0;
      known_count = '0;
    end
    return res;
  endfunction

  function automatic logic [WordW-1:0] random_word();
    logic [WordW-1:0] chars;
    logic [7:0]       ch;
    for (int i = 0; i < WordBytes; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        ch = 8'($urandom_range(32, 126));
      end else begin
        ch = CharUpperA + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 1) == 1) ch = ch + CaseOffset;
      end
      chars[8*i +: 8] = ch;
    end
    return chars;
  endfunction

  // flip letter case at random, fill bytes past the length with junk
  function automatic logic [WordW-1:0] shape_word(logic [WordW-1:0] chars,
                                                  logic [LenW-1:0] len);
    logic [WordW-1:0] shaped;
    logic [7:0]       ch;
    for (int i = 0; i < WordBytes; i++) begin
      ch = chars[8*i +: 8];
      if (i >= len) begin
        ch = 8'($urandom);
      end else if (is_letter(ch) && $urandom_range(0, 1) == 1) begin
        ch = ch ^ CaseOffset;
      end
      shaped[8*i +: 8] = ch;
    end
    return shaped;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d want %0d", $time, field, got, want);
  endtask

  always @(posedge clk_i) begin : watch
    rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (awaited_tallies.size() == 0) begin
          report_mismatch("result with none pending", 1, 0);
        end else begin
          want = awaited_tallies.pop_front();
          if (rsp_o.is_new !== want.is_new)
            report_mismatch("is_new", rsp_o.is_new, want.is_new);
          if (rsp_o.distinct_count !== want.distinct_count)
            report_mismatch("distinct_count", rsp_o.distinct_count, want.distinct_count);
          if (rsp_o.table_full !== want.table_full)
            report_mismatch("table_full", rsp_o.table_full, want.table_full);
          if (rsp_o.list_done !== want.list_done)
            report_mismatch("list_done", rsp_o.list_done, want.list_done);
        end
      end
      if (start_i && !busy_o) begin
        want = tally_word(req_i);
        if (row_pinned) want = row_rsp;
        awaited_tallies.insert(awaited_tallies.size(), want);
      end
    end
  end

  task automatic issue_word(req_t r, logic pinned, rsp_t rsp);
    start_i <= 1'b1;
    req_i <= r;
    row_pinned <= pinned;
    row_rsp <= rsp;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic hold_off(int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (awaited_tallies.size() != 0);
  endtask

  task automatic add_row(logic [WordW-1:0] chars, logic [LenW-1:0] len, logic last,
                         logic pinned, logic is_new, logic [CountW-1:0] count,
                         logic full, logic done);
    word_row_t row;
    row.req.word_chars = chars;
    row.req.word_len = len;
    row.req.last_word = last;
    row.pinned = pinned;
    row.rsp.is_new = is_new;
    row.rsp.distinct_count = count;
    row.rsp.table_full = full;
    row.rsp.list_done = done;
    word_rows.insert(word_rows.size(), row);
  endtask

  initial begin : stimulus
    req_t r;
    int   sent;
    int   list_len;
    int   gap_odds;
    int   pick;
    logic noisy;
    logic calm;
    start_i = 1'b0;
    req_i = '0;
    row_pinned = 1'b0;
    row_rsp = '0;
    rst_ni = 1'b0;
    mismatches = 0;
    known_valid = '0;
    known_count = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(64'h0000_006F_6C6C_6548, 4'd5, 1'b0, 1'b1, 1'b1, 5'd1, 1'b0, 1'b0);
    add_row(64'h0000_006F_6C6C_6568, 4'd5, 1'b0, 1'b1, 1'b0, 5'd1, 1'b0, 1'b0);
    add_row(64'hA5C3_FF4F_4C4C_4548, 4'd5, 1'b0, 1'b1, 1'b0, 5'd1, 1'b0, 1'b0);
    add_row('1,                      4'd0, 1'b0, 1'b1, 1'b1, 5'd2, 1'b0, 1'b0);
    add_row('0,                      4'd0, 1'b0, 1'b1, 1'b0, 5'd2, 1'b0, 1'b0);
    add_row('1,                      4'd9, 1'b0, 1'b1, 1'b0, 5'd2, 1'b0, 1'b0);
    add_row('1,                      4'd15, 1'b0, 1'b1, 1'b0, 5'd2, 1'b0, 1'b0);
    add_row('1,                      4'd8, 1'b0, 1'b1, 1'b1, 5'd3, 1'b0, 1'b0);
    add_row(64'h7B7A_6160_5B5A_4140, 4'd8, 1'b0, 1'b0, 1'b0, 5'd0, 1'b0, 1'b0);
    add_row(64'h7B5A_4160_5B7A_6140, 4'd8, 1'b0, 1'b0, 1'b0, 5'd0, 1'b0, 1'b0);
    add_row(64'h0000_0000_0000_0061, 4'd1, 1'b0, 1'b0, 1'b0, 5'd0, 1'b0, 1'b0);
    add_row(64'hFFFF_FFFF_FFFF_0041, 4'd2, 1'b0, 1'b0, 1'b0, 5'd0, 1'b0, 1'b0);
    for (int i = 0; i < 11; i++)
      add_row(64'h3077 + (64'(i) << 8), 4'd2, 1'b0, 1'b0, 1'b0, 5'd0, 1'b0, 1'b0);
    add_row(64'h0000_0000_0000_7A7A, 4'd2, 1'b0, 1'b1, 1'b1, 5'd16, 1'b1, 1'b0);
    add_row('1,                      4'd12, 1'b1, 1'b1, 1'b0, 5'd16, 1'b0, 1'b1);
    add_row(64'h0000_004F_4C4C_4548, 4'd5, 1'b1, 1'b1, 1'b1, 5'd1, 1'b0, 1'b1);

    foreach (word_rows[i]) begin
      issue_word(word_rows[i].req, word_rows[i].pinned, word_rows[i].rsp);
      if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 6));
    end
    drain();

    for (int p = 0; p < PoolSize; p++) begin
      pool_chars[p] = random_word();
      pool_len[p] = LenW'($urandom_range(1, WordChars));
    end

    sent = 0;
    while (sent < RandomItems) begin
      list_len = $urandom_range(1, 40);
      gap_odds = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(2, 5);
      noisy = ($urandom_range(0, 5) == 0);
      for (int k = 0; k < list_len && sent < RandomItems; k++) begin
        calm = (sent >= RandomItems - CalmTail);
        pick = $urandom_range(0, 19);
        if (noisy) begin
          r.word_chars = {$urandom, $urandom};
          r.word_len = LenW'($urandom_range(0, 15));
          r.last_word = ($urandom_range(0, 7) == 0);
        end else begin
          if (pick == 0) begin
            r.word_chars = {$urandom, $urandom};
            r.word_len = LenW'($urandom_range(WordChars + 1, 15));
          end else if (pick <= 2) begin
            r.word_len = LenW'($urandom_range(0, WordChars));
            r.word_chars = shape_word(random_word(), r.word_len);
          end else begin
            pick = $urandom_range(0, PoolSize - 1);
            r.word_len = pool_len[pick];
            r.word_chars = shape_word(pool_chars[pick], r.word_len);
          end
          r.last_word = (k == list_len - 1);
        end
        issue_word(r, 1'b0, '0);
        sent++;
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
          hold_off($urandom_range(1, 6));
        if (sent == RandomItems / 2) drain();
      end
    end

    drain();
    hold_off(SettleCycles);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
